/* rtl/qdiv_pkg.sv */
// ----------------------------------------------------------------------------
// qdiv_pkg
// Types and constants shared by the Q15 saturating divider pipeline.
// ----------------------------------------------------------------------------
package qdiv_pkg;

    localparam int DATA_W     = 16;  // Q15 word width
    localparam int FRAC_BITS  = 15;  // quotient bits produced by the divider
    localparam int STEPS_PER_STAGE = 3;
    localparam int NUM_STAGES = FRAC_BITS / STEPS_PER_STAGE;

    localparam logic [DATA_W-1:0] Q15_MAX = 16'h7FFF;
    localparam logic [DATA_W-1:0] Q15_MIN = 16'h8000;

    // Payload carried between the divider stages
    typedef struct packed {
        logic [DATA_W-1:0]    rem;   // partial remainder, below den unless ovf is set
        logic [DATA_W-1:0]    den;   // divisor magnitude
        logic [FRAC_BITS-1:0] quo;   // quotient bits so far
        logic                 neg;   // result is negative
        logic                 ovf;   // saturate (also zero divisor)
        logic                 last;  // end of vector flag
    } div_word_t;

endpackage

/* rtl/qdiv_if.sv */
// ----------------------------------------------------------------------------
// qdiv_in_if / qdiv_out_if
// Valid/ready channels for operand pairs and quotients.
// ----------------------------------------------------------------------------
interface qdiv_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dividend;
    logic signed [15:0] divisor;
    logic               last_in;

    modport source (output valid, output dividend, output divisor, output last_in,
                    input ready);
    modport sink   (input valid, input dividend, input divisor, input last_in,
                    output ready);
endinterface

interface qdiv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quotient;
    logic               last_out;

    modport source (output valid, output quotient, output last_out, input ready);
    modport sink   (input valid, input quotient, input last_out, output ready);
endinterface

/* rtl/qdiv_prep.sv */
// ----------------------------------------------------------------------------
// qdiv_prep
// Input stage: takes magnitudes, classifies sign, saturation and zero divisor.
// ----------------------------------------------------------------------------
module qdiv_prep (
    input  logic                clk,
    input  logic                rst_n,
    qdiv_in_if.sink             in_ch,
    output logic                valid,
    input  logic                ready,
    output qdiv_pkg::div_word_t data
);

    logic                valid_reg;
    qdiv_pkg::div_word_t data_reg;
    qdiv_pkg::div_word_t data_next;
    logic [15:0]         num_mag;
    logic [15:0]         den_mag;
    logic                den_zero;
    logic                advance;

    assign advance     = !valid_reg || ready;
    assign in_ch.ready = advance;

    // Magnitudes; the most negative value maps to 0x8000 unsigned
    assign num_mag  = in_ch.dividend[15] ? (16'd0 - in_ch.dividend) : in_ch.dividend;
    assign den_mag  = in_ch.divisor[15]  ? (16'd0 - in_ch.divisor)  : in_ch.divisor;
    assign den_zero = (in_ch.divisor == 16'sd0);

    // |num| >= |den| means the quotient magnitude reaches 2^15
    always_comb
    begin
        data_next.rem  = num_mag;
        data_next.den  = den_mag;
        data_next.quo  = '0;
        data_next.ovf  = den_zero || (num_mag >= den_mag);
        data_next.neg  = !den_zero && (in_ch.dividend != 16'sd0)
                         && (in_ch.dividend[15] != in_ch.divisor[15]);
        data_next.last = in_ch.last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_ch.valid)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* rtl/qdiv_stage.sv */
// ----------------------------------------------------------------------------
// qdiv_stage
// One divider pipeline stage: STEPS_PER_STAGE restoring division steps, registered.
// ----------------------------------------------------------------------------
module qdiv_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qdiv_pkg::div_word_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qdiv_pkg::div_word_t out_data
);

    logic                valid_reg;
    qdiv_pkg::div_word_t data_reg;
    qdiv_pkg::div_word_t data_next;
    logic                advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // Shift-compare-subtract, one quotient bit per step
    always_comb
    begin
        logic [qdiv_pkg::DATA_W:0] trial;
        data_next = in_data;
        for (int i = 0; i < qdiv_pkg::STEPS_PER_STAGE; i++)
        begin
            trial = {data_next.rem, 1'b0};
            if (trial >= {1'b0, data_next.den})
            begin
                trial         = trial - {1'b0, data_next.den};
                data_next.quo = {data_next.quo[qdiv_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                data_next.quo = {data_next.quo[qdiv_pkg::FRAC_BITS-2:0], 1'b0};
            end
            data_next.rem = trial[qdiv_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/qdiv_fix.sv */
// ----------------------------------------------------------------------------
// qdiv_fix
// Output stage: applies sign and saturation, registers the result transfer.
// ----------------------------------------------------------------------------
module qdiv_fix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qdiv_pkg::div_word_t in_data,
    qdiv_out_if.source          out_ch
);

    logic        valid_reg;
    logic [15:0] quo_reg;
    logic [15:0] quo_next;
    logic        last_reg;
    logic        advance;

    assign advance  = !valid_reg || out_ch.ready;
    assign in_ready = advance;

    // Saturate, else negate the magnitude when the signs differ
    always_comb
    begin
        if (in_data.ovf)
            quo_next = in_data.neg ? qdiv_pkg::Q15_MIN : qdiv_pkg::Q15_MAX;
        else if (in_data.neg)
            quo_next = 16'd0 - {1'b0, in_data.quo};
        else
            quo_next = {1'b0, in_data.quo};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            quo_reg  <= quo_next;
            last_reg <= in_data.last;
        end
    end

    assign out_ch.valid    = valid_reg;
    assign out_ch.quotient = quo_reg;
    assign out_ch.last_out = last_reg;

endmodule

/* rtl/q15_saturating_divider.sv */
// ----------------------------------------------------------------------------
// q15_saturating_divider
// Q15 divide with truncation toward zero and saturation to 16 bits.
// Pipeline: prep register, five divider stages of three quotient bits
//   each, then the output register.
// Throughput: one item per cycle while not stalled; a stall holds full stages.
// Reset: asynchronous, active low; clears only the stage valid bits.
// ----------------------------------------------------------------------------
module q15_saturating_divider (
    input  logic       clk,
    input  logic       rst_n,
    qdiv_in_if.sink    in_ch,
    qdiv_out_if.source out_ch
);

    localparam int N = qdiv_pkg::NUM_STAGES;

    logic                valid [N+1];
    logic                ready [N+1];
    qdiv_pkg::div_word_t data  [N+1];

    // Operand preparation
    qdiv_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .valid (valid[0]),
        .ready (ready[0]),
        .data  (data[0])
    );

    // Divider stages
    for (genvar s = 0; s < N; s++)
    begin : g_div
        qdiv_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[s]),
            .in_ready  (ready[s]),
            .in_data   (data[s]),
            .out_valid (valid[s+1]),
            .out_ready (ready[s+1]),
            .out_data  (data[s+1])
        );
    end

    // Sign, saturation and output register
    qdiv_fix u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid[N]),
        .in_ready (ready[N]),
        .in_data  (data[N]),
        .out_ch   (out_ch)
    );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Q15 saturating divider. A short directed table
// covers zero divisors, saturation at both ends and exact boundary quotients.
// Random operand pairs follow, biased towards quotients that stay in range.
// Each result is compared with a local model of the divide, or with a typed
// row's hand-worked quotient; sender and receiver are throttled in turn.
// ----------------------------------------------------------------------------
module testbench;

    // Throttling schemes applied to the two channels
    typedef enum logic [1:0] {PH_FLOW, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} throttle_t;

    // One quotient as it should leave the block
    typedef struct packed {
        logic signed [qdiv_pkg::DATA_W-1:0] quotient;
        logic                               last;
    } quot_t;

    // Directed row: operands, flag, and a hand-worked quotient where typed is set
    typedef struct packed {
        logic signed [qdiv_pkg::DATA_W-1:0] dividend;
        logic signed [qdiv_pkg::DATA_W-1:0] divisor;
        logic                               last;
        logic                               typed;
        logic signed [qdiv_pkg::DATA_W-1:0] quotient;
    } dir_row_t;

    localparam int N_DIR       = 24;
    localparam int N_PER_PHASE = 240;
    localparam int DRAIN_CYC   = 20;

    logic      clk;
    logic      rst_n;
    throttle_t phase;
    int        errors = 0;
    quot_t     pending_quotients [$];

    qdiv_in_if  in_ch ();
    qdiv_out_if out_ch ();

    q15_saturating_divider u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    dir_row_t dir_rows [0:N_DIR-1] = '{
        '{16'sd0,      16'sd0,      1'b0, 1'b1, 16'sd32767},   // zero divisor
        '{16'sd32767,  16'sd0,      1'b1, 1'b1, 16'sd32767},
        '{-16'sd32768, 16'sd0,      1'b0, 1'b1, 16'sd32767},
        '{16'sd0,      16'sd12345,  1'b0, 1'b1, 16'sd0},
        '{16'sd32767,  16'sd32767,  1'b0, 1'b1, 16'sd32767},   // clamps high
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 16'sd32767},
        '{-16'sd32768, 16'sd1,      1'b0, 1'b1, -16'sd32768},  // clamps low
        '{16'sd32767,  -16'sd1,     1'b0, 1'b1, -16'sd32768},
        '{-16'sd32768, 16'sd32767,  1'b0, 1'b1, -16'sd32768},
        '{16'sd32767,  -16'sd32768, 1'b0, 1'b1, -16'sd32767},
        '{16'sd16384,  -16'sd32768, 1'b1, 1'b1, -16'sd16384},
        '{16'sd1,      16'sd2,      1'b0, 1'b1, 16'sd16384},
        '{-16'sd1,     16'sd3,      1'b0, 1'b0, 16'sd0},       // truncates toward zero
        '{16'sd1,      -16'sd3,     1'b0, 1'b0, 16'sd0},
        '{16'sd16383,  16'sd16384,  1'b0, 1'b0, 16'sd0},
        '{-16'sd16384, 16'sd16384,  1'b0, 1'b1, -16'sd32768},  // exact minimum
        '{16'sd16384,  16'sd16384,  1'b0, 1'b1, 16'sd32767},
        '{-16'sd32767, 16'sd32767,  1'b0, 1'b1, -16'sd32768},
        '{16'sd32766,  16'sd32767,  1'b0, 1'b0, 16'sd0},
        '{16'sd1,      16'sd32767,  1'b0, 1'b0, 16'sd0},
        '{-16'sd1,     -16'sd32768, 1'b1, 1'b1, 16'sd1},
        '{16'sd12345,  -16'sd23456, 1'b0, 1'b0, 16'sd0},
        '{-16'sd21000, -16'sd30001, 1'b1, 1'b0, 16'sd0},
        '{16'sd21845,  16'sd21846,  1'b0, 1'b0, 16'sd0}
    };

    // Saturating Q15 divide, truncating toward zero
    function automatic quot_t divide_q15(input logic signed [qdiv_pkg::DATA_W-1:0] num,
                                         input logic signed [qdiv_pkg::DATA_W-1:0] den,
                                         input logic                               lst);
        quot_t  r;
        longint scaled;
        longint q;
        r.last = lst;
        if (den == 0)
            r.quotient = qdiv_pkg::Q15_MAX;
        else
        begin
            scaled = longint'(num) * (64'sd1 <<< qdiv_pkg::FRAC_BITS);
            q      = scaled / longint'(den);
            if (q > longint'($signed(qdiv_pkg::Q15_MAX)))
                r.quotient = qdiv_pkg::Q15_MAX;
            else if (q < longint'($signed(qdiv_pkg::Q15_MIN)))
                r.quotient = qdiv_pkg::Q15_MIN;
            else
                r.quotient = q[qdiv_pkg::DATA_W-1:0];
        end
        return r;
    endfunction

    // Present one operand pair and log its quotient once the transfer happens
    task automatic issue_operands(input logic signed [qdiv_pkg::DATA_W-1:0] num,
                                  input logic signed [qdiv_pkg::DATA_W-1:0] den,
                                  input logic                               lst,
                                  input logic                               typed,
                                  input logic signed [qdiv_pkg::DATA_W-1:0] typed_q);
        quot_t want;
        while ((phase == PH_SRC_IDLE && $urandom_range(99) < 61) ||
               (phase == PH_BOTH && $urandom_range(99) < 23))
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.dividend <= num;
        in_ch.divisor  <= den;
        in_ch.last_in  <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        want = divide_q15(num, den, lst);
        if (typed)
            want.quotient = typed_q;
        pending_quotients.push_back(want);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // Result transfers: compare with the oldest quotient, then pick next ready
    always @(posedge clk)
    begin
        quot_t want;
        logic  stall;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_quotients.size() == 0)
            begin
                $error("unexpected result: quotient %0d last_out %0b",
                       out_ch.quotient, out_ch.last_out);
                errors++;
            end
            else
            begin
                want = pending_quotients.pop_front();
                if (out_ch.quotient !== want.quotient)
                begin
                    $error("quotient: expected %0d, got %0d", want.quotient, out_ch.quotient);
                    errors++;
                end
                if (out_ch.last_out !== want.last)
                begin
                    $error("last_out: expected %0b, got %0b", want.last, out_ch.last_out);
                    errors++;
                end
            end
        end
        case (phase)
            PH_SNK_STALL: stall = ($urandom_range(99) < 61);
            PH_BOTH:      stall = ($urandom_range(99) < 23);
            default:      stall = 1'b0;
        endcase
        out_ch.ready <= rst_n && !stall;
    end

    // Stimulus
    initial
    begin
        logic signed [qdiv_pkg::DATA_W-1:0] a;
        logic signed [qdiv_pkg::DATA_W-1:0] b;
        logic                               l;
        int                                 sel;
        int                                 mag;
        int                                 num_mag;
        phase  = PH_FLOW;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.dividend <= '0;
        in_ch.divisor  <= '0;
        in_ch.last_in  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < N_DIR; i++)
            issue_operands(dir_rows[i].dividend, dir_rows[i].divisor, dir_rows[i].last,
                           dir_rows[i].typed, dir_rows[i].quotient);

        // Random pairs, one throttling scheme after another
        for (int p = 0; p < 4; p++)
        begin
            phase = throttle_t'(p);
            for (int k = 0; k < N_PER_PHASE; k++)
            begin
                sel = $urandom_range(99);
                l   = ($urandom_range(7) == 0);
                if (sel < 40)
                begin
                    // in range: dividend magnitude below divisor magnitude
                    mag     = $urandom_range(32767, 1);
                    num_mag = $urandom_range(mag - 1, 0);
                    b = 16'($urandom_range(1) ? -mag : mag);
                    a = 16'($urandom_range(1) ? -num_mag : num_mag);
                end
                else if (sel < 60)
                begin
                    a = 16'($urandom());
                    b = 16'($urandom());
                end
                else if (sel < 75)
                begin
                    // tiny divisors, mostly saturating
                    mag = $urandom_range(16, 1);
                    b = 16'($urandom_range(1) ? -mag : mag);
                    a = 16'($urandom());
                end
                else if (sel < 85)
                begin
                    a = 16'($urandom());
                    b = '0;
                end
                else
                begin
                    // corner operand values on one or both sides
                    case ($urandom_range(4))
                        0: a = qdiv_pkg::Q15_MAX;
                        1: a = qdiv_pkg::Q15_MIN;
                        2: a = 16'sd1;
                        3: a = -16'sd1;
                        default: a = 16'($urandom());
                    endcase
                    case ($urandom_range(4))
                        0: b = qdiv_pkg::Q15_MAX;
                        1: b = qdiv_pkg::Q15_MIN;
                        2: b = 16'sd1;
                        3: b = -16'sd1;
                        default: b = 16'($urandom());
                    endcase
                end
                issue_operands(a, b, l, 1'b0, '0);
            end
        end

        // Drain
        in_ch.valid <= 1'b0;
        phase = PH_FLOW;
        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
